### rtl/pema_pkg.sv
// Shared constants and types for the pitch error metric accumulator.
// No dependencies; imported by every module under rtl/.
package pema_pkg;

	localparam int LOG_FRAC_BITS = 16;
	localparam int COUNT_BITS    = 32;

	localparam int VAL_W  = 32;
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 64;
	localparam int LOG_W  = 5 + LOG_FRAC_BITS;
	localparam int IT_W   = $clog2(LOG_FRAC_BITS);
	localparam int CENT_W = 28;
	localparam int RMSE_W = 32;
	localparam int VUV_W  = 23;

	localparam logic [MUL_W-1:0] LOG2E_Q30   = MUL_W'(1549082005);
	localparam logic [MUL_W-1:0] CENT_SCALE  = MUL_W'(1200);
	localparam logic [MUL_W-1:0] PCT_SCALE   = MUL_W'(6553600);
	localparam logic [VAL_W-1:0] LOG_UNVOICED = 32'h8000_0000;

	localparam int CENT_SH = LOG_FRAC_BITS - 8;
	localparam int LN_SH   = 54 - LOG_FRAC_BITS;

	localparam logic [1:0] FMT_PERIOD = 2'd0;
	localparam logic [1:0] FMT_F0     = 2'd1;
	localparam logic [1:0] FMT_LNF0   = 2'd2;
	localparam logic [1:0] FMT_RSVD   = 2'd3;

	localparam logic [1:0] SEL_BOTH = 2'd0;
	localparam logic [1:0] SEL_RMSE = 2'd1;
	localparam logic [1:0] SEL_VUV  = 2'd2;
	localparam logic [1:0] SEL_NONE = 2'd3;

	localparam logic [1:0] REG_VALUE_FMT     = 2'd0;
	localparam logic [1:0] REG_OUTPUT_SELECT = 2'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

### rtl/pema_div.sv
// Restoring divider, one quotient bit per cycle (64-bit dividend).
// Depends on pema_pkg.
module pema_div import pema_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ACC_W-1:0]      dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic [ACC_W-1:0]      quotient,
	output unit_stat_t            stat
);

	localparam int CNT_W = $clog2(ACC_W);

	logic [COUNT_BITS-1:0] rem_q, dsr_q;
	logic [ACC_W-1:0]      dvd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q, done_q;
	logic [COUNT_BITS:0]   sh;
	logic [COUNT_BITS:0]   diff;

	assign sh   = {rem_q, dvd_q[ACC_W-1]};
	assign diff = sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[COUNT_BITS]) begin
				rem_q <= diff[COUNT_BITS-1:0];
				dvd_q <= {dvd_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[COUNT_BITS-1:0];
				dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/pema_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on pema_pkg.
module pema_sqrt import pema_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  radicand,
	output logic [RMSE_W-1:0] root,
	output unit_stat_t        stat
);

	localparam int STEPS = ACC_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [ACC_W-1:0] x_q, res_q, bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [ACC_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root      = res_q[RMSE_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/pitch_error_metric_accumulator_unit.sv
// Pitch error metric accumulator top level: sequencer, shared multiplier, accumulators.
// Depends on pema_pkg, pema_div, pema_sqrt.
//
// Takes one pair of pitch frames per request and keeps a saturating sum of squared cent
// errors plus voiced, mismatch and frame counters. The request flagged by tlast is counted
// and then yields one result (F0 RMSE in cents Q24.8, V/UV error percent Q7.16, flags),
// after which all accumulators clear; no other request yields a result. The block takes
// one request at a time and drops s_tready while it works. An unvoiced or mismatched pair
// only updates the counters; a natural-log F0 pair is scaled to log2 on the one shared
// multiplier; a period or F0 pair has each value normalized and run through the log2
// squaring loop on that multiplier. Each voiced pair is then scaled to cents, squared
// and accumulated. A tlast request also uses the 64-step divider (run once for RMSE,
// once for V/UV) and the 32-step square root. A finished result sits in the output
// register while the next run is accepted. Configuration writes are taken every cycle
// and must only be issued while the block is idle.
module pitch_error_metric_accumulator_unit import pema_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_index: 0 value format, 1 output_select
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // [31:0] value_ref, [63:32] value_test
	input  logic        s_tlast,    // last_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // [31:0] rmse_cents, [54:32] vuv_percent, [55] zero
	output logic [2:0]  m_tuser     // [0] rmse_valid, [1] vuv_valid, [2] no_voiced_error
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_NORM  = 5'd1;
	localparam logic [4:0] ST_LMUL  = 5'd2;
	localparam logic [4:0] ST_LUPD  = 5'd3;
	localparam logic [4:0] ST_MAG   = 5'd4;
	localparam logic [4:0] ST_LNMUL = 5'd5;
	localparam logic [4:0] ST_LN    = 5'd6;
	localparam logic [4:0] ST_CMUL  = 5'd7;
	localparam logic [4:0] ST_CENT  = 5'd8;
	localparam logic [4:0] ST_SMUL  = 5'd9;
	localparam logic [4:0] ST_ACC   = 5'd10;
	localparam logic [4:0] ST_FIN   = 5'd11;
	localparam logic [4:0] ST_DIVR  = 5'd12;
	localparam logic [4:0] ST_SQRT  = 5'd13;
	localparam logic [4:0] ST_VMUL  = 5'd14;
	localparam logic [4:0] ST_VDIV0 = 5'd15;
	localparam logic [4:0] ST_VDIV  = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	localparam logic [PROD_W-1:0] CENT_HALF = (PROD_W'(1) << CENT_SH) >> 1;
	localparam logic [PROD_W-1:0] LN_HALF   = (PROD_W'(1) << LN_SH) >> 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [4:0]            state_q;
	logic [1:0]            fmt_q, osel_q;

	// accumulators
	logic [ACC_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] voiced_q, mismatch_q, total_q;

	// per-request working registers
	logic [VAL_W-1:0]      b_q;
	logic                  last_q;
	logic [VAL_W-1:0]      m_q;
	logic [4:0]            p_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [IT_W-1:0]       it_q;
	logic                  sel_q;
	logic [LOG_W-1:0]      la_q;
	logic [MUL_W-1:0]      mag_q;
	logic [CENT_W-1:0]     cents_q;
	logic [PROD_W-1:0]     prod_q;

	// pending result and output register
	logic [RMSE_W-1:0]     res_rmse_q;
	logic [VUV_W-1:0]      res_vuv_q;
	logic                  res_rv_q, res_uv_q, res_nve_q;
	logic [RMSE_W-1:0]     out_rmse_q;
	logic [VUV_W-1:0]      out_vuv_q;
	logic [2:0]            out_flags_q;
	logic                  out_valid_q;

	logic [MUL_W-1:0]      mul_a, mul_b;
	logic                  accept;
	logic [VAL_W-1:0]      in_a, in_b, unv;
	logic                  va, vb;
	logic signed [VAL_W:0] ln_diff;
	logic [VAL_W-1:0]      ln_abs;
	logic [LOG_FRAC_BITS-1:0] frac_next;
	logic [LOG_W-1:0]      log_now;
	logic [PROD_W-1:0]     cent_round, ln_round;
	logic [ACC_W:0]        sum_ext;
	logic                  want_rmse, want_vuv;
	logic                  out_free;

	logic                  div_start, sqrt_start;
	logic [ACC_W-1:0]      div_dividend, div_quot;
	logic [COUNT_BITS-1:0] div_divisor;
	logic [RMSE_W-1:0]     sqrt_root;
	unit_stat_t            div_stat, sqrt_stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_a      = s_tdata[31:0];
	assign in_b      = s_tdata[63:32];
	assign unv       = (fmt_q == FMT_LNF0) ? LOG_UNVOICED : '0;
	assign va        = (in_a != unv);
	assign vb        = (in_b != unv);
	assign ln_diff   = $signed({in_a[VAL_W-1], in_a}) - $signed({in_b[VAL_W-1], in_b});
	assign ln_abs    = ln_diff[VAL_W] ? VAL_W'(-ln_diff) : ln_diff[VAL_W-1:0];

	assign frac_next  = {frac_q[LOG_FRAC_BITS-2:0], prod_q[63]};
	assign log_now    = {p_q, frac_next};
	assign cent_round = (prod_q + CENT_HALF) >> CENT_SH;
	assign ln_round   = (prod_q + LN_HALF) >> LN_SH;
	assign sum_ext    = {1'b0, sum_q} + {1'b0, prod_q[ACC_W-1:0]};

	assign want_rmse = (osel_q == SEL_BOTH) || (osel_q == SEL_RMSE);
	assign want_vuv  = (osel_q == SEL_BOTH) || (osel_q == SEL_VUV);
	assign out_free  = !out_valid_q || m_tready;

	// shared multiplier operand select; product registered every cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LMUL: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			ST_LNMUL: begin
				mul_a = mag_q;
				mul_b = LOG2E_Q30;
			end
			ST_CMUL: begin
				mul_a = mag_q;
				mul_b = CENT_SCALE;
			end
			ST_SMUL: begin
				mul_a = MUL_W'(cents_q);
				mul_b = MUL_W'(cents_q);
			end
			ST_VMUL: begin
				mul_a = MUL_W'(mismatch_q);
				mul_b = PCT_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign div_start    = ((state_q == ST_FIN) && want_rmse && (voiced_q != '0)) ||
		(state_q == ST_VDIV0);
	assign div_dividend = (state_q == ST_VDIV0) ? prod_q[ACC_W-1:0] : sum_q;
	assign div_divisor  = (state_q == ST_VDIV0) ? total_q : voiced_q;
	assign sqrt_start   = (state_q == ST_DIVR) && div_stat.done;

	pema_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	pema_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot),
		.root     (sqrt_root),
		.stat     (sqrt_stat)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_PERIOD;
			osel_q <= SEL_BOTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VALUE_FMT:     fmt_q  <= cfg_data;
				REG_OUTPUT_SELECT: osel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			voiced_q    <= '0;
			mismatch_q  <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a new result or drop the one just taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (total_q != CNT_MAX)
							total_q <= total_q + 1'b1;
						if (va && vb) begin
							if (voiced_q != CNT_MAX)
								voiced_q <= voiced_q + 1'b1;
							state_q <= (fmt_q == FMT_LNF0) ? ST_LNMUL : ST_NORM;
						end else begin
							if (va != vb && mismatch_q != CNT_MAX)
								mismatch_q <= mismatch_q + 1'b1;
							state_q <= s_tlast ? ST_FIN : ST_IDLE;
						end
					end
				end
				ST_NORM: begin
					if (m_q[VAL_W-1])
						state_q <= ST_LMUL;
				end
				ST_LMUL: state_q <= ST_LUPD;
				ST_LUPD: begin
					if (it_q == IT_W'(LOG_FRAC_BITS - 1))
						state_q <= sel_q ? ST_MAG : ST_NORM;
					else
						state_q <= ST_LMUL;
				end
				ST_MAG:   state_q <= ST_CMUL;
				ST_LNMUL: state_q <= ST_LN;
				ST_LN:    state_q <= ST_CMUL;
				ST_CMUL:  state_q <= ST_CENT;
				ST_CENT:  state_q <= ST_SMUL;
				ST_SMUL:  state_q <= ST_ACC;
				ST_ACC: begin
					sum_q   <= sum_ext[ACC_W] ? '1 : sum_ext[ACC_W-1:0];
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (want_rmse && voiced_q == '0)
						state_q <= ST_OUT;
					else if (want_rmse)
						state_q <= ST_DIVR;
					else if (want_vuv)
						state_q <= ST_VMUL;
					else
						state_q <= ST_OUT;
				end
				ST_DIVR: begin
					if (div_stat.done)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sqrt_stat.done)
						state_q <= want_vuv ? ST_VMUL : ST_OUT;
				end
				ST_VMUL:  state_q <= ST_VDIV0;
				ST_VDIV0: state_q <= ST_VDIV;
				ST_VDIV: begin
					if (div_stat.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						sum_q       <= '0;
						voiced_q    <= '0;
						mismatch_q  <= '0;
						total_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					b_q    <= in_b;
					last_q <= s_tlast;
					m_q    <= in_a;
					p_q    <= 5'd31;
					frac_q <= '0;
					it_q   <= '0;
					sel_q  <= 1'b0;
					mag_q  <= MUL_W'(ln_abs);
				end
			end
			ST_NORM: begin
				if (!m_q[VAL_W-1]) begin
					if (m_q[VAL_W-1 -: 8] == 8'd0) begin
						m_q <= m_q << 8;
						p_q <= p_q - 5'd8;
					end else begin
						m_q <= m_q << 1;
						p_q <= p_q - 5'd1;
					end
				end
			end
			ST_LUPD: begin
				m_q    <= prod_q[63] ? prod_q[63:32] : prod_q[62:31];
				frac_q <= frac_next;
				it_q   <= it_q + 1'b1;
				if (it_q == IT_W'(LOG_FRAC_BITS - 1)) begin
					it_q <= '0;
					if (!sel_q) begin
						// first value done, start on the second
						la_q   <= log_now;
						m_q    <= b_q;
						p_q    <= 5'd31;
						frac_q <= '0;
						sel_q  <= 1'b1;
					end else begin
						mag_q <= (la_q >= log_now) ? MUL_W'(la_q - log_now) :
							MUL_W'(log_now - la_q);
					end
				end
			end
			ST_LN:   mag_q   <= ln_round[MUL_W-1:0];
			ST_CENT: cents_q <= cent_round[CENT_W-1:0];
			ST_FIN: begin
				res_rmse_q <= '0;
				res_vuv_q  <= '0;
				res_rv_q   <= 1'b0;
				res_uv_q   <= 1'b0;
				res_nve_q  <= want_rmse && (voiced_q == '0);
			end
			ST_SQRT: begin
				if (sqrt_stat.done) begin
					res_rmse_q <= sqrt_root;
					res_rv_q   <= 1'b1;
				end
			end
			ST_VDIV: begin
				if (div_stat.done) begin
					res_vuv_q <= div_quot[VUV_W-1:0];
					res_uv_q  <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_rmse_q  <= res_rmse_q;
					out_vuv_q   <= res_vuv_q;
					out_flags_q <= {res_nve_q, res_uv_q, res_rv_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_vuv_q, out_rmse_q};
	assign m_tuser  = out_flags_q;

	// no-voiced error withholds both metrics
	a_nve_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[2] && (m_tuser[0] || m_tuser[1])))
		else $error("no-voiced error reported together with a metric");

	// every counted frame is counted in total as well
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		(voiced_q <= total_q) && (mismatch_q <= total_q))
		else $error("pair counters exceed frame count");

	// divider is never restarted mid-run
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// square root is never restarted mid-run
	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_stat.busy)
		else $error("square root started while busy");

	// a result appears only after the final-metrics path
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result loaded outside output state");

endmodule
